// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPL(lbl, clk, rst, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/bstl_pkg.sv -----
`timescale 1ns / 1ps
package bstl_pkg;
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_COUNT  = 2'd1,
      PH_RECORD = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   localparam int HeaderBytes = 80;
   localparam int WordBytes   = 4;
   localparam int AttrBytes   = 2;
   localparam int RecordBytes = 12 * WordBytes + AttrBytes;

   // one completed triple handed from front to back
   typedef struct packed {
      logic        vertex;
      logic        first_vtx;
      logic        final_pt;
      logic        clear_box;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] tri_idx;
   } triple_type;

   // ieee single a < b; false if either is nan, +0 == -0
   function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic both_zero;
      logic res;
      a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (a_nan || b_nan || both_zero) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (a[31] == 1'b0) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction
endpackage

// ----- sv/bstl_front.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bstl_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_file_start,
   output logic                   req_stall,
   output logic                   trp_valid,
   output bstl_pkg::triple_type   trp_data,
   input  logic                   trp_stall
);
   import bstl_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [6:0]  pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] hx_ff, hx_in;
   logic [31:0] hy_ff, hy_in;
   logic [31:0] decl_ff, decl_in;
   logic [31:0] cur_ff, cur_in;
   logic        started_ff, started_in;
   logic        clr_ff, clr_in;
   logic        tv_ff, tv_in;
   triple_type  td_ff, td_in;

   logic        take;
   phase_type   ph;
   logic [6:0]  p;
   logic [31:0] hx, hy, decl, cur;
   logic        started, clr;
   logic [1:0]  comp;
   logic [1:0]  trip;

   assign req_stall = tv_ff && trp_stall;
   assign take      = req_valid && !req_stall;
   assign trp_valid = tv_ff;
   assign trp_data  = td_ff;
   assign asm_in    = take ? {req_data_byte, asm_ff[31:8]} : asm_ff;

   // word position within a record
   always_comb begin
      comp = 2'd0;
      trip = 2'd0;
      case (p[6:2])
         5'd0:  begin comp = 2'd0; trip = 2'd0; end
         5'd1:  begin comp = 2'd1; trip = 2'd0; end
         5'd2:  begin comp = 2'd2; trip = 2'd0; end
         5'd3:  begin comp = 2'd0; trip = 2'd1; end
         5'd4:  begin comp = 2'd1; trip = 2'd1; end
         5'd5:  begin comp = 2'd2; trip = 2'd1; end
         5'd6:  begin comp = 2'd0; trip = 2'd2; end
         5'd7:  begin comp = 2'd1; trip = 2'd2; end
         5'd8:  begin comp = 2'd2; trip = 2'd2; end
         5'd9:  begin comp = 2'd0; trip = 2'd3; end
         5'd10: begin comp = 2'd1; trip = 2'd3; end
         5'd11: begin comp = 2'd2; trip = 2'd3; end
         default: begin comp = 2'd3; trip = 2'd0; end
      endcase
   end

   // byte parser
   always_comb begin
      ph = phase_ff; p = pos_ff; hx = hx_ff; hy = hy_ff;
      decl = decl_ff; cur = cur_ff; started = started_ff; clr = clr_ff;
      if (req_file_start) begin
         ph = PH_HEADER; p = 7'd0; hx = '0; hy = '0;
         decl = '0; cur = '0; started = 1'b0; clr = 1'b1;
      end
      phase_in = ph; pos_in = p; hx_in = hx; hy_in = hy;
      decl_in = decl; cur_in = cur; started_in = started; clr_in = clr;
      tv_in = tv_ff && trp_stall;
      td_in = td_ff;
      if (take) begin
         case (ph)
            PH_HEADER: begin
               if (p == 7'(HeaderBytes - 1)) begin
                  phase_in = PH_COUNT; pos_in = 7'd0;
               end else begin
                  pos_in = p + 7'd1;
               end
            end
            PH_COUNT: begin
               if (p == 7'(WordBytes - 1)) begin
                  decl_in = asm_in; cur_in = '0; pos_in = 7'd0;
                  phase_in = (asm_in == 32'd0) ? PH_DONE : PH_RECORD;
               end else begin
                  pos_in = p + 7'd1;
               end
            end
            PH_RECORD: begin
               if (p[1:0] == 2'd3 && comp != 2'd3) begin
                  if (comp == 2'd0) begin
                     hx_in = asm_in;
                  end else if (comp == 2'd1) begin
                     hy_in = asm_in;
                  end else begin
                     tv_in = 1'b1;
                     td_in.vertex    = trip != 2'd0;
                     td_in.first_vtx = (trip != 2'd0) && !started;
                     td_in.final_pt  = (trip == 2'd3) && (cur == decl - 32'd1);
                     td_in.clear_box = clr;
                     td_in.x = hx; td_in.y = hy; td_in.z = asm_in;
                     td_in.tri_idx = cur;
                     clr_in = 1'b0;
                     if (trip != 2'd0) started_in = 1'b1;
                  end
               end
               if (p == 7'(RecordBytes - 1)) begin
                  pos_in = 7'd0;
                  cur_in = cur + 32'd1;
                  if (cur + 32'd1 == decl) phase_in = PH_DONE;
               end else begin
                  pos_in = p + 7'd1;
               end
            end
            default: begin
            end
         endcase
      end else begin
         phase_in = phase_ff; pos_in = pos_ff; hx_in = hx_ff; hy_in = hy_ff;
         decl_in = decl_ff; cur_in = cur_ff; started_in = started_ff;
         clr_in = clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; pos_ff <= '0; asm_ff <= '0;
         decl_ff <= '0; cur_ff <= '0; started_ff <= 1'b0;
         clr_ff <= 1'b1; tv_ff <= 1'b0; hx_ff <= '0; hy_ff <= '0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; asm_ff <= asm_in;
         decl_ff <= decl_in; cur_ff <= cur_in; started_ff <= started_in;
         clr_ff <= clr_in; tv_ff <= tv_in; hx_ff <= hx_in; hy_ff <= hy_in;
      end
      td_ff <= td_in;
   end

   `CHK_IMPL(a_pos_rng, clock, reset, phase_ff == PH_RECORD, pos_ff < 7'(RecordBytes), "record position out of range")
   `CHK_IMPL(a_hdr_rng, clock, reset, phase_ff == PH_HEADER, pos_ff < 7'(HeaderBytes), "header position out of range")
   `CHK_NEXT(a_done_quiet, clock, reset, phase_ff == PH_DONE && !req_file_start && !tv_ff, !tv_ff, "output after done")
endmodule

// ----- sv/bstl_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bstl_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 trp_valid,
   input  bstl_pkg::triple_type trp_data,
   output logic                 trp_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_point_kind,
   output logic [31:0]          rsp_x_bits,
   output logic [31:0]          rsp_y_bits,
   output logic [31:0]          rsp_z_bits,
   output logic [31:0]          rsp_triangle_index,
   output logic                 rsp_final_point,
   output logic [31:0]          rsp_box_min_x,
   output logic [31:0]          rsp_box_max_x,
   output logic [31:0]          rsp_box_min_y,
   output logic [31:0]          rsp_box_max_y,
   output logic [31:0]          rsp_box_min_z,
   output logic [31:0]          rsp_box_max_z
);
   import bstl_pkg::*;

   logic [31:0] box_ff [6];
   logic [31:0] box_in [6];
   logic [31:0] cur [6];
   logic [31:0] v [3];
   logic        ov_ff, ov_in;
   triple_type  od_ff;
   logic [31:0] obox_ff [6];
   logic        take;

   assign trp_stall = ov_ff && rsp_stall;
   assign take      = trp_valid && !trp_stall;
   assign ov_in     = take || (ov_ff && rsp_stall);
   assign v[0] = trp_data.x;
   assign v[1] = trp_data.y;
   assign v[2] = trp_data.z;

   // running box update
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         cur[i] = trp_data.clear_box ? 32'd0 : box_ff[i];
      end
      for (int a = 0; a < 3; a++) begin
         box_in[2*a]   = cur[2*a];
         box_in[2*a+1] = cur[2*a+1];
         if (trp_data.vertex) begin
            if (trp_data.first_vtx || flt_lt(v[a], cur[2*a])) box_in[2*a] = v[a];
            if (trp_data.first_vtx || flt_lt(cur[2*a+1], v[a])) box_in[2*a+1] = v[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
      if (take) begin
         od_ff <= trp_data;
         for (int i = 0; i < 6; i++) begin
            box_ff[i]  <= box_in[i];
            obox_ff[i] <= box_in[i];
         end
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_point_kind     = od_ff.vertex;
   assign rsp_x_bits         = od_ff.x;
   assign rsp_y_bits         = od_ff.y;
   assign rsp_z_bits         = od_ff.z;
   assign rsp_triangle_index = od_ff.tri_idx;
   assign rsp_final_point    = od_ff.final_pt;
   assign rsp_box_min_x      = obox_ff[0];
   assign rsp_box_max_x      = obox_ff[1];
   assign rsp_box_min_y      = obox_ff[2];
   assign rsp_box_max_y      = obox_ff[3];
   assign rsp_box_min_z      = obox_ff[4];
   assign rsp_box_max_z      = obox_ff[5];

   `CHK_NEXT(a_hold, clock, reset, ov_ff && rsp_stall, ov_ff && $stable(od_ff), "result dropped while stalled")
   `CHK_IMPL(a_final_vtx, clock, reset, ov_ff && od_ff.final_pt, od_ff.vertex, "final flag on a normal")
   `CHK_NEXT(a_first_box, clock, reset, take && trp_data.first_vtx, obox_ff[0] == od_ff.x && obox_ff[5] == od_ff.z, "first vertex box")
endmodule

// ----- sv/binary_stl_parser_bbox.sv -----
`timescale 1ns / 1ps
// binary stl parser with running bounding box
// throughput: one byte per cycle while req_stall is low, set by the byte parser's state update
// path: after its last byte, a result is held in the front register, then in the back register
// reset: synchronous, active high; clears parse phase and counters and arms the box clear for the next triple
module binary_stl_parser_bbox (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_point_kind,
   output logic [31:0] rsp_x_bits,
   output logic [31:0] rsp_y_bits,
   output logic [31:0] rsp_z_bits,
   output logic [31:0] rsp_triangle_index,
   output logic        rsp_final_point,
   output logic [31:0] rsp_box_min_x,
   output logic [31:0] rsp_box_max_x,
   output logic [31:0] rsp_box_min_y,
   output logic [31:0] rsp_box_max_y,
   output logic [31:0] rsp_box_min_z,
   output logic [31:0] rsp_box_max_z
);
   import bstl_pkg::*;

   logic       trp_valid;
   logic       trp_stall;
   triple_type trp_data;

   bstl_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data_byte(req_data_byte),
      .req_file_start(req_file_start), .req_stall(req_stall),
      .trp_valid(trp_valid), .trp_data(trp_data), .trp_stall(trp_stall)
   );

   bstl_back u_back (
      .clock(clock), .reset(reset),
      .trp_valid(trp_valid), .trp_data(trp_data), .trp_stall(trp_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_kind(rsp_point_kind), .rsp_x_bits(rsp_x_bits),
      .rsp_y_bits(rsp_y_bits), .rsp_z_bits(rsp_z_bits),
      .rsp_triangle_index(rsp_triangle_index), .rsp_final_point(rsp_final_point),
      .rsp_box_min_x(rsp_box_min_x), .rsp_box_max_x(rsp_box_max_x),
      .rsp_box_min_y(rsp_box_min_y), .rsp_box_max_y(rsp_box_max_y),
      .rsp_box_min_z(rsp_box_min_z), .rsp_box_max_z(rsp_box_max_z)
   );
endmodule
